// ----- rtl/core/soc_pkg.sv -----
package soc_pkg;

    // %K is Q8 percent: 25600 stands for 100 percent
    localparam int K_W = 15;
    localparam int K_BIT_W = $clog2(K_W);
    localparam logic [K_W-1:0] K_FULL_SCALE = 15'd25600;

    // Result transaction layout
    localparam int OUT_W = ((2 * K_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // Configuration port
    localparam int PERIOD_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_K = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_D = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_K_RST = 7'd14;
    localparam logic [PERIOD_W-1:0] PERIOD_D_RST = 7'd3;
    localparam logic [31:0] PERIOD_MIN = 32'd2;

    // Clamp a period register to 2..maxp
    function automatic logic [31:0] clamp_period(input logic [PERIOD_W-1:0] v,
                                                 input int unsigned maxp);
        logic [31:0] ve;
        ve = 32'(v);
        if (ve < PERIOD_MIN) begin
            return PERIOD_MIN;
        end else if (ve > 32'(maxp)) begin
            return 32'(maxp);
        end
        return ve;
    endfunction

endpackage

// ----- rtl/core/soc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle
module soc_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   trial;
    logic             fit;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {r_rem, r_quot[NUM_W-1]};
    assign trial  = rem_sh - {1'b0, r_den};
    assign fit    = !trial[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift register (quotient starts as dividend)
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= fit ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/soc_ratio.sv -----
// floor(25600 * num / den) for num < den, per quotient bit:
// double the remainder, then add num where the scale constant has a one.
module soc_ratio
    import soc_pkg::*;
#(
    parameter int PW = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [PW-1:0]  i_num,
    input  logic [PW-1:0]  i_den,
    output logic           o_done,
    output logic [K_W-1:0] o_q
);

    logic               r_busy;
    logic               r_done;
    logic               r_phase;
    logic [K_BIT_W-1:0] r_bit;
    logic [PW-1:0]      r_rem;
    logic [PW-1:0]      r_num;
    logic [PW-1:0]      r_den;
    logic [K_W-1:0]     r_q;

    logic [PW:0] dbl;
    logic [PW:0] dbl_t;
    logic        dbl_fit;
    logic [PW:0] add;
    logic [PW:0] add_t;
    logic        add_fit;
    logic        bit_set;
    logic        last;
    logic        finish;

    // Remainder stays below den, so each step needs one add and compare
    assign dbl     = {r_rem, 1'b0};
    assign dbl_fit = dbl >= {1'b0, r_den};
    assign dbl_t   = dbl - {1'b0, r_den};
    assign add     = {1'b0, r_rem} + {1'b0, r_num};
    assign add_fit = add >= {1'b0, r_den};
    assign add_t   = add - {1'b0, r_den};
    assign bit_set = K_FULL_SCALE[r_bit];
    assign last    = (r_bit == '0);
    assign finish  = r_busy && last && (r_phase || !bit_set);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_done <= finish;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_bit   <= K_BIT_W'(K_W - 1);
            end else if (r_busy) begin
                if (!r_phase && bit_set) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    if (last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_bit <= r_bit - K_BIT_W'(1);
                    end
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_rem <= dbl_fit ? dbl_t[PW-1:0] : dbl[PW-1:0];
                r_q   <= {r_q[K_W-2:0], dbl_fit};
            end else begin
                r_rem <= add_fit ? add_t[PW-1:0] : add[PW-1:0];
                r_q   <= r_q + K_W'(add_fit);
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ----- rtl/core/stochastic_oscillator.sv -----
// Stochastic oscillator: one price bar (high, low, close) in, one result out with
// %K and %D in Q8 percent (25600 = 100 percent) and a valid flag for each. Highs and
// lows sit in a ring memory of MAX_PERIOD_K entries, %K values in a second ring of
// MAX_PERIOD_D entries. While the price window is still filling a bar goes from the
// accept straight to the output load. Otherwise the min/max walk reads one entry per
// cycle over the K window, the %K ratio unit runs (15 quotient bits, 3 of them with an
// extra add step; skipped when the range is flat or close is at or outside it), the
// %K ring read-modify-write goes through a read state and an update state, once the
// %D window is full the serial %D divide runs over the K_W + clog2(MAX_PERIOD_D + 1)
// bits of the %K sum, and the output load waits for the output register to be free.
// A new bar is taken while the previous result still waits in the output register.
// Register writes are taken only while no bar is in progress and hold off a new bar
// in the same cycle; writing the K window length empties the price window, writing
// the D window length empties the %K window.
module stochastic_oscillator
    import soc_pkg::*;
#(
    parameter int MAX_PERIOD_K = 64,
    parameter int MAX_PERIOD_D = 64,
    parameter int PRICE_WIDTH  = 32,
    localparam int IN_W = ((3 * PRICE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // bar input; tdata: high_price, low_price, close_price
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    // result; tdata: k_value, d_value; tuser: k_valid, d_valid
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PERIOD_W-1:0]   i_cfg_data
);

    localparam int AKW   = $clog2(MAX_PERIOD_K);
    localparam int PKW   = $clog2(MAX_PERIOD_K + 1);
    localparam int ADW   = $clog2(MAX_PERIOD_D);
    localparam int PDW   = $clog2(MAX_PERIOD_D + 1);
    localparam int SUM_W = K_W + PDW;
    localparam int PW    = PRICE_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_RATIO = 7'b0000100,
        S_KRD   = 7'b0001000,
        S_KUPD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    // Configuration and window control
    logic [PERIOD_W-1:0] r_k_len;
    logic [PERIOD_W-1:0] r_d_len;
    logic [AKW-1:0]      r_price_head;
    logic [PKW-1:0]      r_price_fill;
    logic [ADW-1:0]      r_k_head;
    logic [PDW-1:0]      r_k_fill;
    logic [SUM_W-1:0]    r_k_sum;
    logic [PKW-1:0]      r_scan_idx;
    logic                r_rd_vld;
    logic                r_out_valid;

    // Item payload
    logic [PW-1:0]  r_close;
    logic [PW-1:0]  r_highest;
    logic [PW-1:0]  r_lowest;
    logic [K_W-1:0] r_k;
    logic [K_W-1:0] r_d;
    logic           r_res_kv;
    logic           r_res_dv;
    logic [K_W-1:0] r_out_k;
    logic [K_W-1:0] r_out_d;
    logic           r_out_kv;
    logic           r_out_dv;

    // Memories
    logic [2*PW-1:0] r_price_mem [MAX_PERIOD_K];
    logic [2*PW-1:0] r_price_q;
    logic [K_W-1:0]  r_k_mem [MAX_PERIOD_D];
    logic [K_W-1:0]  r_k_q;

    logic [31:0]     pk32;
    logic [31:0]     pd32;
    logic [PKW-1:0]  pk;
    logic [PDW-1:0]  pd;
    logic [PW-1:0]   hi_in;
    logic [PW-1:0]   lo_in;
    logic [PW-1:0]   cl_in;
    logic            in_accept;
    logic            cfg_accept;
    logic [AKW-1:0]  price_slot;
    logic [PKW-1:0]  price_inc;
    logic [AKW-1:0]  n_price_head;
    logic [PKW-1:0]  n_price_fill;
    logic            price_full;
    logic            scan_issue;
    logic            scan_done;
    logic [PW-1:0]   q_high;
    logic [PW-1:0]   q_low;
    logic            k_flat;
    logic            k_top;
    logic            ratio_start;
    logic            ratio_done;
    logic [K_W-1:0]  ratio_q;
    logic [ADW-1:0]  k_slot;
    logic [PDW-1:0]  k_inc;
    logic [ADW-1:0]  n_k_head;
    logic [PDW-1:0]  n_k_fill;
    logic [SUM_W-1:0] n_k_sum;
    logic            k_full;
    logic            div_start;
    logic            div_done;
    logic [SUM_W-1:0] div_q;
    logic            out_load;

    // Effective periods
    assign pk32 = clamp_period(r_k_len, MAX_PERIOD_K);
    assign pd32 = clamp_period(r_d_len, MAX_PERIOD_D);
    assign pk   = PKW'(pk32);
    assign pd   = PDW'(pd32);

    assign hi_in = i_s_axis_tdata[PW-1:0];
    assign lo_in = i_s_axis_tdata[2*PW-1:PW];
    assign cl_in = i_s_axis_tdata[3*PW-1:2*PW];

    // Register writes only between bars; a pending write goes first
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign cfg_accept      = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Price ring pointer and fill
    assign price_slot   = (32'(r_price_head) >= pk32) ? '0 : r_price_head;
    assign price_inc    = PKW'(price_slot) + PKW'(1);
    assign n_price_head = (price_inc >= pk) ? '0 : price_inc[AKW-1:0];
    assign n_price_fill = (r_price_fill < pk) ? r_price_fill + PKW'(1) : r_price_fill;
    assign price_full   = (n_price_fill >= pk);

    // Window walk
    assign scan_issue = (r_scan_idx < pk);
    assign scan_done  = (r_state == S_SCAN) && !scan_issue && !r_rd_vld;
    assign q_high     = r_price_q[2*PW-1:PW];
    assign q_low      = r_price_q[PW-1:0];

    // %K special cases
    assign k_flat      = (r_highest <= r_lowest) || (r_close <= r_lowest);
    assign k_top       = (r_close >= r_highest);
    assign ratio_start = scan_done && !k_flat && !k_top;

    soc_ratio #(
        .PW(PW)
    ) u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ratio_start),
        .i_num   (r_close - r_lowest),
        .i_den   (r_highest - r_lowest),
        .o_done  (ratio_done),
        .o_q     (ratio_q)
    );

    // %K ring pointer, fill and running sum
    assign k_slot    = (32'(r_k_head) >= pd32) ? '0 : r_k_head;
    assign k_inc     = PDW'(k_slot) + PDW'(1);
    assign n_k_head  = (k_inc >= pd) ? '0 : k_inc[ADW-1:0];
    assign n_k_fill  = (r_k_fill < pd) ? r_k_fill + PDW'(1) : r_k_fill;
    assign k_full    = (n_k_fill >= pd);
    assign n_k_sum   = r_k_sum - ((r_k_fill >= pd) ? SUM_W'(r_k_q) : '0) + SUM_W'(r_k);
    assign div_start = (r_state == S_KUPD) && k_full;

    soc_div #(
        .NUM_W(SUM_W),
        .DEN_W(PDW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_k_sum),
        .i_den   (pd),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // Price memory: write on bar transaction, read during the walk
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_price_mem[price_slot] <= {hi_in, lo_in};
        end
        r_price_q <= r_price_mem[r_scan_idx[AKW-1:0]];
    end

    // %K memory: read old entry, then write the new %K to the same slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_KUPD) begin
            r_k_mem[k_slot] <= r_k;
        end
        r_k_q <= r_k_mem[k_slot];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k_len      <= PERIOD_K_RST;
            r_d_len      <= PERIOD_D_RST;
            r_price_head <= '0;
            r_price_fill <= '0;
            r_k_head     <= '0;
            r_k_fill     <= '0;
            r_k_sum      <= '0;
            r_scan_idx   <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN) && scan_issue;
            // Output register holds one result until its transaction
            r_out_valid <= out_load || (r_out_valid && !i_m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_price_head <= n_price_head;
                        r_price_fill <= n_price_fill;
                        r_scan_idx   <= '0;
                        r_state      <= price_full ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_scan_idx <= r_scan_idx + PKW'(1);
                    end
                    if (scan_done) begin
                        r_state <= (k_flat || k_top) ? S_KRD : S_RATIO;
                    end
                end
                S_RATIO: begin
                    if (ratio_done) begin
                        r_state <= S_KRD;
                    end
                end
                S_KRD: begin
                    r_state <= S_KUPD;
                end
                S_KUPD: begin
                    r_k_head <= n_k_head;
                    r_k_fill <= n_k_fill;
                    r_k_sum  <= n_k_sum;
                    r_state  <= k_full ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Register writes, each empties its window
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    CFG_PERIOD_K: begin
                        r_k_len      <= i_cfg_data;
                        r_price_head <= '0;
                        r_price_fill <= '0;
                    end
                    CFG_PERIOD_D: begin
                        r_d_len    <= i_cfg_data;
                        r_k_head   <= '0;
                        r_k_fill   <= '0;
                        r_k_sum    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_close   <= cl_in;
            r_highest <= '0;
            r_lowest  <= '1;
            r_k       <= '0;
            r_d       <= '0;
            r_res_kv  <= 1'b0;
            r_res_dv  <= 1'b0;
        end
        if (r_rd_vld) begin
            if (q_high > r_highest) begin
                r_highest <= q_high;
            end
            if (q_low < r_lowest) begin
                r_lowest <= q_low;
            end
        end
        if (scan_done) begin
            r_k <= k_flat ? '0 : K_FULL_SCALE;
        end
        if ((r_state == S_RATIO) && ratio_done) begin
            r_k <= ratio_q;
        end
        if (r_state == S_KUPD) begin
            r_res_kv <= 1'b1;
            r_res_dv <= k_full;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_d <= div_q[K_W-1:0];
        end
        if (out_load) begin
            r_out_k  <= r_k;
            r_out_d  <= r_d;
            r_out_kv <= r_res_kv;
            r_out_dv <= r_res_dv;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_d, r_out_k});
    assign o_m_axis_tuser  = {r_out_dv, r_out_kv};

    // %K never exceeds full scale
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[K_W-1:0] <= K_FULL_SCALE))
        else $error("percent K above full scale");

    // %D is only given together with %K
    a_d_needs_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tuser[0])
        else $error("percent D valid without percent K");

    // Fill counts never pass their period
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_price_fill <= pk) && (r_k_fill <= pd))
        else $error("window fill beyond period");

    // Ratio unit finishes only while the sequencer waits for it
    a_ratio_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ratio_done |-> (r_state == S_RATIO))
        else $error("ratio result outside ratio state");

endmodule
